FILE: src/usb_device_transfer_sequencer_core_macros.svh
// Assertion helpers shared by the RTL of the transfer sequencer.
`ifndef USB_DEVICE_TRANSFER_SEQUENCER_CORE_MACROS_SVH
`define USB_DEVICE_TRANSFER_SEQUENCER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UDTS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("udts: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define UDTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("udts: next-cycle check failed");

`endif

FILE: src/udts_pkg.sv
package udts_pkg;

  localparam int NUM_EP    = 4;
  localparam int EP_W      = 2;
  localparam int TBL_DEPTH = 2 * NUM_EP;
  localparam int IDX_W     = $clog2(TBL_DEPTH);
  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = RES_IDX_W + 1;
  localparam int ADDR_W    = 4;

  localparam logic [10:0] EP0_PACKET = 11'd64;
  localparam logic [10:0] MPS_MIN    = 11'd8;
  localparam logic [10:0] MPS_MAX    = 11'd1024;
  localparam logic [10:0] MPS_RESET  = 11'd512;

  // Configuration register indexes.
  localparam logic [1:0] REG_EP1_MPS = 2'd0;
  localparam logic [1:0] REG_EP2_MPS = 2'd1;
  localparam logic [1:0] REG_EP3_MPS = 2'd2;

  // Request opcodes.
  localparam logic [2:0] OP_START_SEND = 3'd0;
  localparam logic [2:0] OP_START_RECV = 3'd1;
  localparam logic [2:0] OP_SETUP_READ = 3'd2;
  localparam logic [2:0] OP_STATUS     = 3'd3;
  localparam logic [2:0] OP_EP0_EVENT  = 3'd4;
  localparam logic [2:0] OP_OUT_PACKET = 3'd5;
  localparam logic [2:0] OP_IN_DONE    = 3'd6;

  // Result actions.
  localparam logic [3:0] ACT_ACCEPTED    = 4'd0;
  localparam logic [3:0] ACT_WRITE       = 4'd1;
  localparam logic [3:0] ACT_READ        = 4'd2;
  localparam logic [3:0] ACT_SETUP       = 4'd3;
  localparam logic [3:0] ACT_OUT_DONE    = 4'd4;
  localparam logic [3:0] ACT_IN_DONE     = 4'd5;
  localparam logic [3:0] ACT_STATUS_DONE = 4'd6;
  localparam logic [3:0] ACT_SETUP_END   = 4'd7;
  localparam logic [3:0] ACT_STALL_CLR   = 4'd8;
  localparam logic [3:0] ACT_ERROR       = 4'd9;

  // EP0 control stages.
  localparam logic [2:0] STG_IDLE     = 3'd0;
  localparam logic [2:0] STG_DATA_IN  = 3'd2;
  localparam logic [2:0] STG_DATA_OUT = 3'd3;
  localparam logic [2:0] STG_STATUS   = 3'd4;

  typedef struct packed {
    logic [10:0] ep1;
    logic [10:0] ep2;
    logic [10:0] ep3;
  } mps_cfg_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] tot;
    logic        flg;
  } entry_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [1:0]  ep;
    logic [10:0] count;
    logic [15:0] offset;
    logic        de;
  } res_t;

endpackage

FILE: src/udts_cfg_regs.sv
module udts_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [udts_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output udts_pkg::mps_cfg_t           mps
);

  logic [10:0] ep1_max_packet;
  logic [10:0] ep2_max_packet;
  logic [10:0] ep3_max_packet;
  logic        wr;

  function automatic logic [10:0] clamp_mps(input logic [10:0] v);
    if (v < udts_pkg::MPS_MIN) begin
      return udts_pkg::MPS_MIN;
    end else if (v > udts_pkg::MPS_MAX) begin
      return udts_pkg::MPS_MAX;
    end
    return v;
  endfunction

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ep1_max_packet <= udts_pkg::MPS_RESET;
      ep2_max_packet <= udts_pkg::MPS_RESET;
      ep3_max_packet <= udts_pkg::MPS_RESET;
    end else if (wr) begin
      unique case (paddr[3:2])
        udts_pkg::REG_EP1_MPS: ep1_max_packet <= pwdata[10:0];
        udts_pkg::REG_EP2_MPS: ep2_max_packet <= pwdata[10:0];
        udts_pkg::REG_EP3_MPS: ep3_max_packet <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      udts_pkg::REG_EP1_MPS: prdata = {21'd0, ep1_max_packet};
      udts_pkg::REG_EP2_MPS: prdata = {21'd0, ep2_max_packet};
      udts_pkg::REG_EP3_MPS: prdata = {21'd0, ep3_max_packet};
      default:               prdata = 32'd0;
    endcase
  end

  // Packet sizes are used saturated to the legal range.
  assign mps.ep1 = clamp_mps(ep1_max_packet);
  assign mps.ep2 = clamp_mps(ep2_max_packet);
  assign mps.ep3 = clamp_mps(ep3_max_packet);

endmodule

FILE: src/usb_device_transfer_sequencer_core.sv
// USB device transfer sequencer. A request is taken when start is high and
// busy is low; busy then stays high until every result of that request has
// been shown. A request causes one to four results. The table is read as the
// request is taken, the entry is computed and written back in the execute
// state, and the results are then shown one after another. Results appear
// on the result ports for exactly one cycle each, marked by result_valid,
// with last set on the final one; the receiver cannot stall them, so it must
// take a result in every cycle in which result_valid is high. The transfer
// table (eight entries, OUT endpoints 0..3 then IN endpoints 0..3) has one
// valid bit per entry that reset clears at once, so no clearing pass follows
// reset. Packet sizes of endpoints 1..3 are to be written by the user
// through the APB port while the block is idle; the block does not enforce it.
`include "usb_device_transfer_sequencer_core_macros.svh"

module usb_device_transfer_sequencer_core (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   opcode,
  input  logic [1:0]                   endpoint,
  input  logic [15:0]                  transfer_length,
  input  logic                         zlp_request,
  input  logic                         setup_dir_in,
  input  logic [10:0]                  rx_count,
  input  logic                         csr_rx_ready,
  input  logic                         csr_setup_end,
  input  logic                         csr_sent_stall,
  // result channel
  output logic                         result_valid,
  output logic [3:0]                   action,
  output logic [1:0]                   endpoint_res,
  output logic [10:0]                  byte_count,
  output logic [15:0]                  buffer_offset,
  output logic                         data_end,
  output logic                         last,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [udts_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;

  udts_pkg::mps_cfg_t mps_cfg;

  udts_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mps     (mps_cfg)
  );

  // Captured request fields.
  logic [2:0]  op_q;
  logic [1:0]  ep_q;
  logic [15:0] len_q;
  logic        zlp_q;
  logic        dir_q;
  logic [10:0] cnt_q;
  logic        rxr_q;
  logic        se_q;
  logic        st_q;
  logic [udts_pkg::IDX_W-1:0] idx_q;

  // Control state kept outside the table.
  logic [2:0]                 stage;
  logic [2:0]                 stage_next;
  logic [udts_pkg::NUM_EP-1:0] mask;
  logic [udts_pkg::NUM_EP-1:0] mask_next;

  // Transfer table: synchronous memory with a registered read.
  udts_pkg::entry_t             tbl [udts_pkg::TBL_DEPTH];
  logic [udts_pkg::TBL_DEPTH-1:0] valid;
  udts_pkg::entry_t             rd_data;
  logic                         rd_valid;
  logic [udts_pkg::IDX_W-1:0]   rd_idx;
  logic                         wr_en;
  udts_pkg::entry_t             wr_data;

  // Result queue.
  udts_pkg::res_t               q [udts_pkg::MAX_RES];
  udts_pkg::res_t               q_next [udts_pkg::MAX_RES];
  logic [udts_pkg::RES_CNT_W-1:0] n_q;
  logic [udts_pkg::RES_CNT_W-1:0] n_next;
  logic [udts_pkg::RES_IDX_W-1:0] emit_idx;

  logic accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Table address for the request being accepted. An EP0 event touches the
  // OUT entry of EP0 except in the data-in stage, where it continues the IN
  // transfer.
  always_comb begin
    case (opcode) inside
      udts_pkg::OP_START_SEND, udts_pkg::OP_IN_DONE: begin
        rd_idx = udts_pkg::IDX_W'(udts_pkg::NUM_EP) + udts_pkg::IDX_W'(endpoint);
      end
      udts_pkg::OP_START_RECV, udts_pkg::OP_OUT_PACKET: begin
        rd_idx = udts_pkg::IDX_W'(endpoint);
      end
      udts_pkg::OP_EP0_EVENT: begin
        rd_idx = (stage == udts_pkg::STG_DATA_IN) ?
                 udts_pkg::IDX_W'(udts_pkg::NUM_EP) : '0;
      end
      default: rd_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= tbl[rd_idx];
    end
    if (wr_en) begin
      tbl[idx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= opcode;
      ep_q     <= endpoint;
      len_q    <= transfer_length;
      zlp_q    <= zlp_request;
      dir_q    <= setup_dir_in;
      cnt_q    <= rx_count;
      rxr_q    <= csr_rx_ready;
      se_q     <= csr_setup_end;
      st_q     <= csr_sent_stall;
      idx_q    <= rd_idx;
      rd_valid <= valid[rd_idx];
    end
  end

  // Datapath for the request in the execute cycle. Send and receive
  // arithmetic is computed once and used by whichever branch needs it.
  udts_pkg::entry_t ent;
  udts_pkg::entry_t src;
  udts_pkg::entry_t snd_ent;
  logic [1:0]       ep_eff;
  logic [10:0]      mps;
  logic [10:0]      snd_size;
  logic             snd_short;
  logic [15:0]      snd_off;
  logic             snd_de;
  logic             in_more;
  logic             rcv_bad;
  logic [15:0]      rcv_rem;
  logic [15:0]      rcv_off;
  logic             rcv_done;
  logic             ep_ok;

  always_comb begin
    // An entry never written reads as the reset value.
    ent = rd_valid ? rd_data : '0;

    if ((op_q == udts_pkg::OP_SETUP_READ) || (op_q == udts_pkg::OP_STATUS) ||
        (op_q == udts_pkg::OP_EP0_EVENT)) begin
      ep_eff = 2'd0;
    end else begin
      ep_eff = ep_q;
    end

    case (ep_eff)
      2'd0:    mps = udts_pkg::EP0_PACKET;
      2'd1:    mps = mps_cfg.ep1;
      2'd2:    mps = mps_cfg.ep2;
      default: mps = mps_cfg.ep3;
    endcase

    ep_ok = int'(ep_q) < udts_pkg::NUM_EP;

    // A new send loads the entry before the first packet is cut.
    if (op_q == udts_pkg::OP_START_SEND) begin
      src.rem = len_q;
      src.tot = len_q;
      src.flg = zlp_q;
    end else begin
      src = ent;
    end

    snd_size    = (src.rem < {5'd0, mps}) ? src.rem[10:0] : mps;
    snd_short   = (snd_size < mps);
    snd_off     = src.tot - src.rem;
    snd_ent.rem = src.rem - {5'd0, snd_size};
    snd_ent.tot = src.tot;
    snd_ent.flg = snd_short ? 1'b0 : src.flg;
    snd_de      = (ep_eff == 2'd0) && snd_short;

    in_more  = (ent.rem != 16'd0) || ent.flg;

    rcv_bad  = !mask[ep_eff] || ent.flg || ({5'd0, cnt_q} > ent.rem) || (cnt_q > mps);
    rcv_rem  = ent.rem - {5'd0, cnt_q};
    rcv_off  = ent.tot - ent.rem;
    rcv_done = (cnt_q < mps) || (rcv_rem == 16'd0);
  end

  function automatic udts_pkg::res_t mk_res(input logic [3:0]  act,
                                            input logic [1:0]  ep,
                                            input logic [10:0] cnt,
                                            input logic [15:0] off,
                                            input logic        de);
    udts_pkg::res_t r;
    r.action = act;
    r.ep     = ep;
    r.count  = cnt;
    r.offset = off;
    r.de     = de;
    return r;
  endfunction

  // Decision logic: builds the list of results and the write-back.
  logic do_send;
  logic do_in;
  logic do_recv;

  always_comb begin
    stage_next = stage;
    mask_next  = mask;
    wr_en      = 1'b0;
    wr_data    = snd_ent;
    n_next     = '0;
    do_send    = 1'b0;
    do_in      = 1'b0;
    do_recv    = 1'b0;
    for (int i = 0; i < udts_pkg::MAX_RES; i++) begin
      q_next[i] = '0;
    end

    case (op_q)
      udts_pkg::OP_START_SEND: begin
        if (!ep_ok) begin
          q_next[n_next[udts_pkg::RES_IDX_W-1:0]] = mk_res(udts_pkg::ACT_ERROR, ep_q, '0, '0, 1'b0);
          n_next = n_next + 1'b1;
        end else begin
          do_send = 1'b1;
        end
      end
      udts_pkg::OP_START_RECV: begin
        if (!ep_ok) begin
          q_next[n_next[udts_pkg::RES_IDX_W-1:0]] = mk_res(udts_pkg::ACT_ERROR, ep_q, '0, '0, 1'b0);
          n_next = n_next + 1'b1;
        end else begin
          wr_en       = 1'b1;
          wr_data.rem = len_q;
          wr_data.tot = len_q;
          wr_data.flg = 1'b0;
          mask_next   = mask | (udts_pkg::NUM_EP'(1) << ep_q);
          q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
            mk_res(udts_pkg::ACT_ACCEPTED, ep_q, '0, '0, 1'b0);
          n_next = n_next + 1'b1;
        end
      end
      udts_pkg::OP_SETUP_READ: begin
        // A setup outside the idle stage changes nothing.
        if (stage != udts_pkg::STG_IDLE) begin
          q_next[n_next[udts_pkg::RES_IDX_W-1:0]] = mk_res(udts_pkg::ACT_ERROR, 2'd0, '0, '0, 1'b0);
          n_next = n_next + 1'b1;
        end else begin
          if (!dir_q) begin
            stage_next = udts_pkg::STG_DATA_OUT;
          end
          q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
            mk_res(udts_pkg::ACT_READ, 2'd0, 11'd8, '0, 1'b0);
          n_next = n_next + 1'b1;
        end
      end
      udts_pkg::OP_STATUS: begin
        stage_next = udts_pkg::STG_STATUS;
        q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
          mk_res(udts_pkg::ACT_ACCEPTED, 2'd0, '0, '0, 1'b0);
        n_next = n_next + 1'b1;
      end
      udts_pkg::OP_EP0_EVENT: begin
        case (stage)
          udts_pkg::STG_IDLE: begin
            if (rxr_q) begin
              q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
                mk_res(udts_pkg::ACT_SETUP, 2'd0, '0, '0, 1'b0);
              n_next = n_next + 1'b1;
            end else if (!st_q) begin
              q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
                mk_res(udts_pkg::ACT_ERROR, 2'd0, '0, '0, 1'b0);
              n_next = n_next + 1'b1;
            end
          end
          udts_pkg::STG_DATA_OUT: begin
            if (rxr_q) begin
              do_recv = 1'b1;
            end else if (!st_q) begin
              q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
                mk_res(udts_pkg::ACT_ERROR, 2'd0, '0, '0, 1'b0);
              n_next = n_next + 1'b1;
            end
          end
          udts_pkg::STG_DATA_IN: begin
            do_in = 1'b1;
          end
          udts_pkg::STG_STATUS: begin
            if (se_q) begin
              q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
                mk_res(udts_pkg::ACT_SETUP_END, 2'd0, '0, '0, 1'b0);
              n_next = n_next + 1'b1;
            end
            stage_next = udts_pkg::STG_IDLE;
            q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
              mk_res(udts_pkg::ACT_STATUS_DONE, 2'd0, '0, '0, 1'b0);
            n_next = n_next + 1'b1;
            if (rxr_q) begin
              q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
                mk_res(udts_pkg::ACT_SETUP, 2'd0, '0, '0, 1'b0);
              n_next = n_next + 1'b1;
            end
          end
          default: begin
            q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
              mk_res(udts_pkg::ACT_ERROR, 2'd0, '0, '0, 1'b0);
            n_next = n_next + 1'b1;
          end
        endcase
      end
      udts_pkg::OP_OUT_PACKET: begin
        if (!ep_ok || (ep_q == 2'd0)) begin
          q_next[n_next[udts_pkg::RES_IDX_W-1:0]] = mk_res(udts_pkg::ACT_ERROR, ep_q, '0, '0, 1'b0);
          n_next = n_next + 1'b1;
        end else begin
          do_recv = 1'b1;
        end
      end
      udts_pkg::OP_IN_DONE: begin
        if (!ep_ok || (ep_q == 2'd0)) begin
          q_next[n_next[udts_pkg::RES_IDX_W-1:0]] = mk_res(udts_pkg::ACT_ERROR, ep_q, '0, '0, 1'b0);
          n_next = n_next + 1'b1;
        end else begin
          do_in = 1'b1;
        end
      end
      default: begin
        q_next[n_next[udts_pkg::RES_IDX_W-1:0]] = mk_res(udts_pkg::ACT_ERROR, ep_q, '0, '0, 1'b0);
        n_next = n_next + 1'b1;
      end
    endcase

    // An IN event either sends the next packet or, once nothing remains
    // and no empty packet is owed, reports completion again.
    if (do_in) begin
      if (in_more) begin
        do_send = 1'b1;
      end else begin
        q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
          mk_res(udts_pkg::ACT_IN_DONE, ep_eff, '0, '0, 1'b0);
        n_next = n_next + 1'b1;
      end
    end

    if (do_send) begin
      wr_en   = 1'b1;
      wr_data = snd_ent;
      if (ep_eff == 2'd0) begin
        stage_next = udts_pkg::STG_DATA_IN;
      end
      q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
        mk_res(udts_pkg::ACT_WRITE, ep_eff, snd_size, snd_off, snd_de);
      n_next = n_next + 1'b1;
    end

    // A rejected OUT packet leaves the table and the armed mask untouched.
    if (do_recv) begin
      if (rcv_bad) begin
        q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
          mk_res(udts_pkg::ACT_ERROR, ep_eff, '0, '0, 1'b0);
        n_next = n_next + 1'b1;
      end else begin
        wr_en       = 1'b1;
        wr_data.rem = rcv_rem;
        wr_data.tot = ent.tot;
        wr_data.flg = rcv_done;
        q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
          mk_res(udts_pkg::ACT_READ, ep_eff, cnt_q, rcv_off,
                 (ep_eff == 2'd0) && rcv_done);
        n_next = n_next + 1'b1;
        if (rcv_done) begin
          mask_next = mask & ~(udts_pkg::NUM_EP'(1) << ep_eff);
          q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
            mk_res(udts_pkg::ACT_OUT_DONE, ep_eff, '0, '0, 1'b0);
          n_next = n_next + 1'b1;
        end
      end
    end

    // A sent stall is serviced after everything else and returns EP0 to idle.
    if ((op_q == udts_pkg::OP_EP0_EVENT) && st_q) begin
      stage_next = udts_pkg::STG_IDLE;
      q_next[n_next[udts_pkg::RES_IDX_W-1:0]] =
        mk_res(udts_pkg::ACT_STALL_CLR, 2'd0, '0, '0, 1'b0);
      n_next = n_next + 1'b1;
    end

    // Only the execute cycle may change the table or the control state.
    if (state != S_EXEC) begin
      wr_en      = 1'b0;
      stage_next = stage;
      mask_next  = mask;
    end
  end

  // Sequencer: accept, execute, then one result per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      stage    <= udts_pkg::STG_IDLE;
      mask     <= '0;
      n_q      <= '0;
      emit_idx <= '0;
    end else begin
      stage <= stage_next;
      mask  <= mask_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          n_q      <= n_next;
          emit_idx <= '0;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (last) begin
            state <= S_IDLE;
          end else begin
            emit_idx <= emit_idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      for (int i = 0; i < udts_pkg::MAX_RES; i++) begin
        q[i] <= q_next[i];
      end
    end
  end

  assign result_valid  = (state == S_EMIT);
  assign action        = q[emit_idx].action;
  assign endpoint_res  = q[emit_idx].ep;
  assign byte_count    = q[emit_idx].count;
  assign buffer_offset = q[emit_idx].offset;
  assign data_end      = q[emit_idx].de;
  assign last          = result_valid && ({1'b0, emit_idx} == (n_q - 1'b1));

  // Every request yields at least one result and never more than the queue holds.
  `UDTS_ASSERT_SAME(a_res_count, clk, rst, state == S_EXEC,
    (n_next != '0) && (n_next <= udts_pkg::RES_CNT_W'(udts_pkg::MAX_RES)))
  // An accepted request goes straight to the execute cycle.
  `UDTS_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == S_EXEC)
  // Results of one request come in an unbroken run.
  `UDTS_ASSERT_NEXT(a_run_unbroken, clk, rst, result_valid && !last, result_valid)
  // After the final result the block is ready for the next request.
  `UDTS_ASSERT_NEXT(a_last_idle, clk, rst, result_valid && last, !busy)

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import udts_pkg::*;

  // One request as the driver presents it to the block.
  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  ep;
    logic [15:0] len;
    logic        zlp;
    logic        dir_in;
    logic [10:0] cnt;
    logic        rx_ready;
    logic        setup_end;
    logic        sent_stall;
  } usb_request_t;

  // One result as it leaves the block, including the end-of-request mark.
  typedef struct packed {
    res_t res;
    logic last;
  } usb_result_t;

  // The scoreboard keeps its own copy of the transfer table, the EP0 control
  // stage, the armed mask and the packet sizes. Every accepted request is run
  // through this copy to produce the actions the block should emit, which
  // are queued and then matched in order against what the block shows.
  class sequencer_scoreboard;
    logic [15:0] rem_bytes[8];
    logic [15:0] tot_bytes[8];
    bit          pkt_flag[8];
    logic [2:0]  ctrl_stage;
    logic [3:0]  out_armed;
    logic [10:0] mps_reg[3];
    usb_result_t expected_actions[$];
    usb_result_t step_actions[$];
    int unsigned failures;

    function new();
      for (int i = 0; i < 8; i++) begin
        rem_bytes[i] = '0;
        tot_bytes[i] = '0;
        pkt_flag[i]  = 1'b0;
      end
      ctrl_stage = STG_IDLE;
      out_armed  = '0;
      for (int i = 0; i < 3; i++) mps_reg[i] = MPS_RESET;
      failures = 0;
    endfunction

    // EP0 has a fixed size; the bulk endpoints saturate their register.
    function logic [10:0] max_packet(logic [1:0] ep);
      logic [10:0] v;
      if (ep == 2'd0) return EP0_PACKET;
      v = mps_reg[ep - 1];
      if (v < MPS_MIN) return MPS_MIN;
      if (v > MPS_MAX) return MPS_MAX;
      return v;
    endfunction

    function void emit(logic [3:0] act, logic [1:0] ep, logic [15:0] cnt,
                       logic [15:0] off, logic de);
      usb_result_t r;
      if (step_actions.size() >= MAX_RES) return;
      r.res.action = act;
      r.res.ep     = ep;
      r.res.count  = cnt[10:0];
      r.res.offset = off;
      r.res.de     = de;
      r.last       = 1'b0;
      step_actions.push_back(r);
    endfunction

    // Cut the next IN packet. A packet shorter than the endpoint size ends
    // the transfer and pays off any owed zero-length packet.
    function void send_packet(logic [1:0] ep);
      logic [2:0]  idx;
      logic [15:0] m, r, size;
      logic        is_short, de;
      idx      = {1'b1, ep};
      m        = {5'b0, max_packet(ep)};
      r        = rem_bytes[idx];
      size     = (r < m) ? r : m;
      is_short = size < m;
      de       = 1'b0;
      rem_bytes[idx] = r - size;
      if (ep == 2'd0) begin
        ctrl_stage = STG_DATA_IN;
        de = is_short;
      end
      if (is_short) pkt_flag[idx] = 1'b0;
      emit(ACT_WRITE, ep, size, tot_bytes[idx] - r, de);
    endfunction

    // Take one OUT packet. A short packet or an exhausted transfer ends it.
    function void recv_packet(logic [1:0] ep, logic [10:0] cnt);
      logic [15:0] m, r, off;
      logic        done;
      m = {5'b0, max_packet(ep)};
      r = rem_bytes[ep];
      if (!out_armed[ep] || pkt_flag[ep] || cnt > r || cnt > m) begin
        emit(ACT_ERROR, ep, 0, 0, 0);
        return;
      end
      off = tot_bytes[ep] - r;
      r = r - cnt;
      rem_bytes[ep] = r;
      done = (cnt < m) || (r == 16'd0);
      emit(ACT_READ, ep, cnt, off, (ep == 2'd0) && done);
      if (done) begin
        pkt_flag[ep]  = 1'b1;
        out_armed[ep] = 1'b0;
        emit(ACT_OUT_DONE, ep, 0, 0, 0);
      end
    endfunction

    function void in_event(logic [1:0] ep);
      if (rem_bytes[{1'b1, ep}] != 16'd0 || pkt_flag[{1'b1, ep}]) send_packet(ep);
      else emit(ACT_IN_DONE, ep, 0, 0, 0);
    endfunction

    function void ep0_event(logic rx_ready, logic setup_end, logic stall, logic [10:0] cnt);
      case (ctrl_stage)
        STG_IDLE: begin
          if (rx_ready) emit(ACT_SETUP, 0, 0, 0, 0);
          else if (!stall) emit(ACT_ERROR, 0, 0, 0, 0);
        end
        STG_DATA_OUT: begin
          if (rx_ready) recv_packet(2'd0, cnt);
          else if (!stall) emit(ACT_ERROR, 0, 0, 0, 0);
        end
        STG_DATA_IN: in_event(2'd0);
        STG_STATUS: begin
          if (setup_end) emit(ACT_SETUP_END, 0, 0, 0, 0);
          ctrl_stage = STG_IDLE;
          emit(ACT_STATUS_DONE, 0, 0, 0, 0);
          if (rx_ready) emit(ACT_SETUP, 0, 0, 0, 0);
        end
        default: emit(ACT_ERROR, 0, 0, 0, 0);
      endcase
      // A sent stall is handled after everything else and always ends the
      // control transfer.
      if (stall) begin
        ctrl_stage = STG_IDLE;
        emit(ACT_STALL_CLR, 0, 0, 0, 0);
      end
    endfunction

    // Predict the actions of one accepted request and queue them. The
    // endpoint field is two bits wide, so every endpoint number is in range.
    function void note_request(usb_request_t q);
      usb_result_t r;
      step_actions.delete();
      case (q.op)
        OP_START_SEND: begin
          rem_bytes[{1'b1, q.ep}] = q.len;
          tot_bytes[{1'b1, q.ep}] = q.len;
          pkt_flag[{1'b1, q.ep}]  = q.zlp;
          send_packet(q.ep);
        end
        OP_START_RECV: begin
          rem_bytes[q.ep] = q.len;
          tot_bytes[q.ep] = q.len;
          pkt_flag[q.ep]  = 1'b0;
          out_armed[q.ep] = 1'b1;
          emit(ACT_ACCEPTED, q.ep, 0, 0, 0);
        end
        OP_SETUP_READ: begin
          if (ctrl_stage != STG_IDLE) begin
            emit(ACT_ERROR, 0, 0, 0, 0);
          end else begin
            if (!q.dir_in) ctrl_stage = STG_DATA_OUT;
            emit(ACT_READ, 0, 16'd8, 0, 0);
          end
        end
        OP_STATUS: begin
          ctrl_stage = STG_STATUS;
          emit(ACT_ACCEPTED, 0, 0, 0, 0);
        end
        OP_EP0_EVENT: ep0_event(q.rx_ready, q.setup_end, q.sent_stall, q.cnt);
        OP_OUT_PACKET: begin
          if (q.ep == 2'd0) emit(ACT_ERROR, q.ep, 0, 0, 0);
          else recv_packet(q.ep, q.cnt);
        end
        OP_IN_DONE: begin
          if (q.ep == 2'd0) emit(ACT_ERROR, q.ep, 0, 0, 0);
          else in_event(q.ep);
        end
        default: emit(ACT_ERROR, q.ep, 0, 0, 0);
      endcase
      if (step_actions.size() > 0) begin
        r = step_actions.pop_back();
        r.last = 1'b1;
        step_actions.push_back(r);
      end
      foreach (step_actions[i]) expected_actions.push_back(step_actions[i]);
    endfunction

    function void report_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function string describe(usb_result_t r);
      return $sformatf("act=%0d ep=%0d cnt=%0d off=%0d de=%0b last=%0b", r.res.action,
                       r.res.ep, r.res.count, r.res.offset, r.res.de, r.last);
    endfunction

    function void check_action(usb_result_t got);
      usb_result_t want;
      if (expected_actions.size() == 0) begin
        report_failure({"unexpected result: ", describe(got)});
        return;
      end
      want = expected_actions.pop_front();
      if (got.res.action !== want.res.action || got.res.ep !== want.res.ep ||
          got.res.count !== want.res.count || got.res.offset !== want.res.offset ||
          got.res.de !== want.res.de || got.last !== want.last)
        report_failure({"result mismatch: expected ", describe(want), ", got ",
                        describe(got)});
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode = '0;
  logic [1:0]  endpoint = '0;
  logic [15:0] transfer_length = '0;
  logic        zlp_request = 1'b0;
  logic        setup_dir_in = 1'b0;
  logic [10:0] rx_count = '0;
  logic        csr_rx_ready = 1'b0;
  logic        csr_setup_end = 1'b0;
  logic        csr_sent_stall = 1'b0;
  logic        result_valid;
  logic [3:0]  action;
  logic [1:0]  endpoint_res;
  logic [10:0] byte_count;
  logic [15:0] buffer_offset;
  logic        data_end;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sequencer_scoreboard sb = new();
  int unsigned issued = 0;

  usb_device_transfer_sequencer_core dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .opcode(opcode), .endpoint(endpoint), .transfer_length(transfer_length),
    .zlp_request(zlp_request), .setup_dir_in(setup_dir_in), .rx_count(rx_count),
    .csr_rx_ready(csr_rx_ready), .csr_setup_end(csr_setup_end),
    .csr_sent_stall(csr_sent_stall),
    .result_valid(result_valid), .action(action), .endpoint_res(endpoint_res),
    .byte_count(byte_count), .buffer_offset(buffer_offset), .data_end(data_end),
    .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results cannot be held off, so every strobed cycle is checked at the
  // edge that closes it.
  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_action({action, endpoint_res, byte_count, buffer_offset, data_end, last});
  end

  // The slowest correct run is roughly 500 requests; the limit here allows
  // many times as long.
  initial begin
    #3_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Present one request, starting at a falling edge, and return at the
  // falling edge after it has been accepted. Start stays high on return so
  // that a back-to-back request needs no second assignment. Every third
  // stretch of forty requests runs without gaps.
  task automatic issue(usb_request_t q);
    int unsigned gap;
    gap = ((issued / 40) % 3 == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode          = q.op;
    endpoint        = q.ep;
    transfer_length = q.len;
    zlp_request     = q.zlp;
    setup_dir_in    = q.dir_in;
    rx_count        = q.cnt;
    csr_rx_ready    = q.rx_ready;
    csr_setup_end   = q.setup_end;
    csr_sent_stall  = q.sent_stall;
    start           = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(q);
    issued++;
    @(negedge clk);
  endtask

  task automatic directed(logic [2:0] op, logic [1:0] ep, logic [15:0] len, logic zlp,
                          logic dir_in, logic [10:0] cnt, logic rx_ready,
                          logic setup_end, logic stall);
    usb_request_t q;
    q.op = op;
    q.ep = ep;
    q.len = len;
    q.zlp = zlp;
    q.dir_in = dir_in;
    q.cnt = cnt;
    q.rx_ready = rx_ready;
    q.setup_end = setup_end;
    q.sent_stall = stall;
    issue(q);
  endtask

  // Every field random within its range; sequences override what matters.
  function automatic usb_request_t rand_request();
    usb_request_t q;
    q.op         = 3'($urandom_range(0, 6));
    q.ep         = 2'($urandom_range(0, 3));
    q.len        = 16'($urandom());
    q.zlp        = 1'($urandom());
    q.dir_in     = 1'($urandom());
    q.cnt        = 11'($urandom_range(0, 1024));
    q.rx_ready   = 1'($urandom());
    q.setup_end  = 1'($urandom());
    q.sent_stall = 1'($urandom());
    return q;
  endfunction

  // A packet size the OUT entry of this endpoint will take: mostly the largest
  // such size, otherwise a random size up to it, which ends the transfer when short.
  function automatic logic [10:0] legal_count(logic [1:0] ep);
    int unsigned lim;
    lim = sb.max_packet(ep);
    if (sb.rem_bytes[ep] < lim) lim = sb.rem_bytes[ep];
    if ($urandom_range(0, 9) < 7) return 11'(lim);
    return 11'($urandom_range(0, lim));
  endfunction

  // Wait until every predicted result has been seen, then let the block
  // settle for longer than a request can take, and leave start low.
  task automatic wait_quiet();
    start = 1'b0;
    while (sb.expected_actions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one packet-size register, then read it back in the next transfer.
  task automatic cfg_write(logic [1:0] idx, logic [10:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = {21'b0, value};
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.mps_reg[idx] = value;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {21'b0, value})
      sb.report_failure($sformatf("register %0d read back %0h, expected %0h", idx,
                                  prdata, value));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Random traffic. Most of it is well-formed control and bulk transfers
  // with random content, the rest is raw noise and deliberately bad packets.
  task automatic run_random(int unsigned target);
    int unsigned  stop_at, kind, len, m, lim;
    logic [1:0]   ep;
    logic         dir_in;
    usb_request_t q;
    stop_at = issued + target;
    while (issued < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        // EP0 control transfer: setup, optional data stage, status stage.
        // A stall brings a stage left open by earlier noise back to idle.
        if (sb.ctrl_stage != STG_IDLE) begin
          q = rand_request();
          q.op = OP_EP0_EVENT;
          q.sent_stall = 1'b1;
          issue(q);
        end
        q = rand_request();
        q.op = OP_SETUP_READ;
        dir_in = q.dir_in;
        issue(q);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000) : $urandom_range(0, 200);
        if (dir_in) begin
          q = rand_request();
          q.op = OP_START_SEND;
          q.ep = 2'd0;
          q.len = 16'(len);
          issue(q);
          while (sb.ctrl_stage == STG_DATA_IN && (sb.rem_bytes[4] != 0 || sb.pkt_flag[4])) begin
            q = rand_request();
            q.op = OP_EP0_EVENT;
            q.sent_stall = ($urandom_range(0, 19) == 0);
            issue(q);
          end
          if (sb.ctrl_stage == STG_DATA_IN) begin
            q = rand_request();
            q.op = OP_EP0_EVENT;
            q.sent_stall = 1'b0;
            issue(q);
          end
        end else if ($urandom_range(0, 3) != 0) begin
          q = rand_request();
          q.op = OP_START_RECV;
          q.ep = 2'd0;
          q.len = 16'(len);
          issue(q);
          while (sb.ctrl_stage == STG_DATA_OUT && sb.out_armed[0] && !sb.pkt_flag[0]) begin
            q = rand_request();
            q.op = OP_EP0_EVENT;
            q.rx_ready = 1'b1;
            q.cnt = legal_count(2'd0);
            q.sent_stall = ($urandom_range(0, 19) == 0);
            issue(q);
          end
        end
        q = rand_request();
        q.op = OP_STATUS;
        issue(q);
        q = rand_request();
        q.op = OP_EP0_EVENT;
        q.sent_stall = ($urandom_range(0, 7) == 0);
        issue(q);
      end else if (kind <= 8) begin
        // Bulk transfer on endpoint 1..3. Lengths that are whole packets
        // are favored so that the owed empty packet gets exercised.
        ep = 2'($urandom_range(1, 3));
        m = sb.max_packet(ep);
        if ($urandom_range(0, 39) == 0 && m == MPS_MAX) len = 65535;
        else if ($urandom_range(0, 2) == 0) len = m * $urandom_range(0, 4);
        else len = $urandom_range(0, 4 * m);
        q = rand_request();
        q.ep = ep;
        q.len = 16'(len);
        if (kind <= 5) begin
          q.op = OP_START_SEND;
          issue(q);
          while (sb.rem_bytes[{1'b1, ep}] != 0 || sb.pkt_flag[{1'b1, ep}]) begin
            q = rand_request();
            q.op = OP_IN_DONE;
            q.ep = ep;
            issue(q);
          end
          q = rand_request();
          q.op = OP_IN_DONE;
          q.ep = ep;
          issue(q);
        end else begin
          q.op = OP_START_RECV;
          issue(q);
          while (sb.out_armed[ep] && !sb.pkt_flag[ep]) begin
            q = rand_request();
            q.op = OP_OUT_PACKET;
            q.ep = ep;
            q.cnt = legal_count(ep);
            // Now and then a larger packet; one too large for what is left or for the
            // endpoint must be refused without changing anything.
            lim = q.cnt;
            if ($urandom_range(0, 9) == 0 && lim < 1024)
              q.cnt = 11'($urandom_range(lim + 1, 1024));
            issue(q);
          end
          if ($urandom_range(0, 3) == 0) begin
            q = rand_request();
            q.op = OP_OUT_PACKET;
            q.ep = ep;
            issue(q);
          end
        end
      end else begin
        repeat ($urandom_range(1, 3)) issue(rand_request());
      end
    end
  endtask

  initial begin
    logic [1:0]  cfg_regs[3];
    logic [10:0] sizes[3];
    cfg_regs[0] = REG_EP1_MPS;
    cfg_regs[1] = REG_EP2_MPS;
    cfg_regs[2] = REG_EP3_MPS;

    repeat (12) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed part, run with the reset packet sizes.
    // Control read: setup, three IN packets of 64, 64 and 2 bytes with DataEnd
    // on the short one, then in_done and a status stage with SetupEnd and a
    // new setup waiting.
    directed(OP_SETUP_READ, 0, 0, 0, 1, 0, 0, 0, 0);
    directed(OP_START_SEND, 0, 130, 0, 0, 0, 0, 0, 0);
    directed(OP_EP0_EVENT, 0, 0, 0, 0, 0, 0, 0, 0);
    directed(OP_EP0_EVENT, 0, 0, 0, 0, 0, 0, 0, 0);
    directed(OP_EP0_EVENT, 0, 0, 0, 0, 0, 0, 0, 0);
    directed(OP_STATUS, 0, 0, 0, 0, 0, 0, 0, 0);
    directed(OP_EP0_EVENT, 0, 0, 0, 0, 0, 1, 1, 0);
    // Control write, a setup arriving out of turn, and an event with no
    // packet waiting in the data stage.
    directed(OP_SETUP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    directed(OP_SETUP_READ, 0, 0, 0, 1, 0, 0, 0, 0);
    directed(OP_START_RECV, 0, 70, 0, 0, 0, 0, 0, 0);
    directed(OP_EP0_EVENT, 0, 0, 0, 0, 64, 1, 0, 0);
    directed(OP_EP0_EVENT, 0, 0, 0, 0, 6, 1, 0, 0);
    directed(OP_EP0_EVENT, 0, 0, 0, 0, 0, 0, 0, 0);
    // Status stage with every status bit set gives four results; then an
    // unexpected event while idle.
    directed(OP_STATUS, 0, 0, 0, 0, 0, 0, 0, 0);
    directed(OP_EP0_EVENT, 0, 0, 0, 0, 0, 1, 1, 1);
    directed(OP_EP0_EVENT, 0, 0, 0, 0, 0, 0, 0, 0);
    // Bulk IN of two full packets with an owed empty packet, then in_done
    // twice after completion.
    directed(OP_START_SEND, 1, 1024, 1, 0, 0, 0, 0, 0);
    directed(OP_IN_DONE, 1, 0, 0, 0, 0, 0, 0, 0);
    directed(OP_IN_DONE, 1, 0, 0, 0, 0, 0, 0, 0);
    directed(OP_IN_DONE, 1, 0, 0, 0, 0, 0, 0, 0);
    directed(OP_IN_DONE, 1, 0, 0, 0, 0, 0, 0, 0);
    // Receives on an endpoint that is not armed, an oversized packet, and
    // bulk events naming EP0.
    directed(OP_OUT_PACKET, 2, 0, 0, 0, 0, 0, 0, 0);
    directed(OP_START_RECV, 3, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    directed(OP_OUT_PACKET, 3, 0, 0, 0, 1024, 0, 0, 0);
    directed(OP_OUT_PACKET, 0, 0, 0, 0, 8, 1, 0, 0);
    directed(OP_IN_DONE, 0, 0, 0, 0, 0, 0, 0, 0);
    directed(OP_START_SEND, 2, 16'hFFFF, 1, 1, 0, 0, 0, 0);

    // Random phases, each under its own packet sizes, reconfigured only once
    // every result of the previous phase has come out.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          sizes[0] = MPS_MIN;
          sizes[1] = MPS_MAX;
          sizes[2] = EP0_PACKET;
        end
        1: begin
          sizes[0] = MPS_MAX;
          sizes[1] = MPS_MIN;
          sizes[2] = 11'd200;
        end
        default: begin
          for (int r = 0; r < 3; r++) sizes[r] = 11'($urandom_range(8, 1024));
        end
      endcase
      wait_quiet();
      for (int r = 0; r < 3; r++) cfg_write(cfg_regs[r], sizes[r]);
      run_random(100);
    end

    // Drain, allowing a bounded wait for results that never show up.
    start = 1'b0;
    for (int w = 0; w < 2000 && sb.expected_actions.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.expected_actions.size() != 0)
      sb.report_failure($sformatf("%0d expected results never arrived",
                                  sb.expected_actions.size()));
    if (sb.failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
